>>> rtl/route_interleave_crossover_core_defines.svh
// Assertion macros used by the route crossover back end.
`ifndef ROUTE_INTERLEAVE_CROSSOVER_CORE_DEFINES_SVH
`define ROUTE_INTERLEAVE_CROSSOVER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RIC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RIC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RIC_ASSERT_ALWAYS(label, cond, msg)
`define RIC_ASSERT_IMPLIES(label, ante, cons, msg)
`define RIC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/ric_pkg.sv
// Shared types, codes and constants of the route crossover block.
package ric_pkg;

    localparam int ROUTE_MAX_DEF   = 32;
    localparam int NODE_COUNT_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int NODE_W      = 6;
    localparam int CC_W        = 5;
    localparam int TH_W        = 17;
    localparam int DRAW_W      = 16;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 17;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam logic [DRAW_W-1:0] HALF_DRAW = 16'd32768;
    localparam logic [CC_W-1:0]   CC_RESET  = 5'd31;
    localparam logic [TH_W-1:0]   TH_RESET  = 17'd58982;

    localparam logic [KIND_W-1:0] KIND_LOAD_ONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_TWO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CUSTOMER_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_THRESHOLD = 1'd1;

    typedef enum logic [1:0] {
        OP_LOAD_ONE,
        OP_LOAD_TWO,
        OP_RUN
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [NODE_W-1:0] node;
        logic              mix;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_LOOK,
        ST_SEL,
        ST_RD,
        ST_WR
    } state_t;

endpackage

>>> rtl/ric_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ric_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ric_front.sv
// Front end: configuration registers, input acceptance and classification.
module ric_front
    import ric_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KIND_W-1:0]    in_kind,
    input  logic [NODE_W-1:0]    in_node,
    input  logic [DRAW_W-1:0]    in_cross,
    input  logic [DRAW_W-1:0]    in_mix,
    input  logic                 q_full,
    output logic                 push,
    output cmd_t                 push_cmd,
    output logic [CC_W-1:0]      customer_count
);

    logic [CC_W-1:0] cc_reg, cc_next;
    logic [TH_W-1:0] th_reg, th_next;
    logic            kind_ok;
    op_t             cmd_op;
    logic            do_mix;

    always_comb
    begin
        cc_next = cc_reg;
        th_next = th_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CUSTOMER_COUNT:  cc_next = cfg_data[CC_W-1:0];
                REG_CROSS_THRESHOLD: th_next = cfg_data[TH_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= CC_RESET;
            th_reg <= TH_RESET;
        end
        else
        begin
            cc_reg <= cc_next;
            th_reg <= th_next;
        end
    end

    // kind three is taken and dropped here
    always_comb
    begin
        cmd_op  = OP_LOAD_ONE;
        kind_ok = 1'b1;
        case (in_kind)
            KIND_LOAD_ONE: cmd_op = OP_LOAD_ONE;
            KIND_LOAD_TWO: cmd_op = OP_LOAD_TWO;
            KIND_RUN:      cmd_op = OP_RUN;
            default:       kind_ok = 1'b0;
        endcase
    end

    assign do_mix = ({1'b0, in_cross} < th_reg) && (in_mix <= HALF_DRAW);

    assign in_ready       = !q_full;
    assign push           = in_valid && !q_full && kind_ok;
    assign push_cmd.op    = cmd_op;
    assign push_cmd.node  = in_node;
    assign push_cmd.mix   = do_mix;
    assign customer_count = cc_reg;

endmodule

>>> rtl/ric_queue.sv
// Short command queue between front end and sequencer.
module ric_queue
    import ric_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    cmd_t            slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

endmodule

>>> rtl/ric_back.sv
// Back end: parent stores, interleave sequencer, child buffers and result output.
`include "route_interleave_crossover_core_defines.svh"
module ric_back
    import ric_pkg::*;
#(
    parameter int ROUTE_MAX  = ROUTE_MAX_DEF,
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CC_W-1:0]   customer_count,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_child,
    output logic [NODE_W-1:0] m_node,
    output logic              m_last
);

    localparam int AW  = $clog2(ROUTE_MAX);
    localparam int LW  = $clog2(ROUTE_MAX + 1);
    localparam int NIW = $clog2(NODE_COUNT);
    localparam logic [LW-1:0]     RM_L = LW'(ROUTE_MAX);
    localparam logic [NODE_W:0]   NC_L = (NODE_W + 1)'(NODE_COUNT);

    state_t            state_reg, state_next;
    logic [LW-1:0]     len1_reg, len1_next, len2_reg, len2_next;
    logic [LW-1:0]     ptr1_reg, ptr1_next, ptr2_reg, ptr2_next;
    logic [CC_W-1:0]   got1_reg, got1_next, got2_reg, got2_next;
    logic [LW-1:0]     n_one_reg, n_one_next, n_two_reg, n_two_next;
    logic              turn_reg, turn_next, cur_reg, cur_next;
    logic              mix_reg, mix_next, side_reg, side_next;
    logic [LW-1:0]     idx_reg, idx_next;
    logic [NODE_COUNT-1:0] seen_reg, seen_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_child_reg;
    logic [NODE_W-1:0] out_node_reg;
    logic              out_last_reg;

    logic              p1_we, p2_we, c1_we, c2_we;
    logic              p1_re, p2_re, c1_re, c2_re;
    logic [AW-1:0]     p1_raddr, p2_raddr;
    logic [NODE_W-1:0] p1_rdata, p2_rdata, c1_rdata, c2_rdata;

    logic              avail1, avail2, pick_side, pick_any;
    logic [NODE_W-1:0] look_data;
    logic              look_cust, look_in_range, look_held, look_full;
    logic [NIW-1:0]    look_idx;
    logic [LW-1:0]     len_a, len_b, sel_len, idx_inc;
    logic              sel_ok, slot_free, out_load, wr_last;
    logic [NODE_W-1:0] wr_data;

    ric_ram #(.WIDTH(NODE_W), .DEPTH(ROUTE_MAX)) u_parent_one (
        .clk   (clk),
        .we    (p1_we),
        .waddr (len1_reg[AW-1:0]),
        .wdata (q_cmd.node),
        .re    (p1_re),
        .raddr (p1_raddr),
        .rdata (p1_rdata)
    );

    ric_ram #(.WIDTH(NODE_W), .DEPTH(ROUTE_MAX)) u_parent_two (
        .clk   (clk),
        .we    (p2_we),
        .waddr (len2_reg[AW-1:0]),
        .wdata (q_cmd.node),
        .re    (p2_re),
        .raddr (p2_raddr),
        .rdata (p2_rdata)
    );

    ric_ram #(.WIDTH(NODE_W), .DEPTH(ROUTE_MAX)) u_child_one (
        .clk   (clk),
        .we    (c1_we),
        .waddr (n_one_reg[AW-1:0]),
        .wdata (look_data),
        .re    (c1_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (c1_rdata)
    );

    ric_ram #(.WIDTH(NODE_W), .DEPTH(ROUTE_MAX)) u_child_two (
        .clk   (clk),
        .we    (c2_we),
        .waddr (n_two_reg[AW-1:0]),
        .wdata (look_data),
        .re    (c2_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (c2_rdata)
    );

    // a parent still has a customer to give while its scan is not done and it has given fewer than customer_count
    assign avail1    = (ptr1_reg < len1_reg) && (got1_reg < customer_count);
    assign avail2    = (ptr2_reg < len2_reg) && (got2_reg < customer_count);
    assign pick_any  = avail1 || avail2;
    assign pick_side = turn_reg ? avail2 : !avail1;

    assign look_data     = cur_reg ? p2_rdata : p1_rdata;
    assign look_cust     = (look_data != '0);
    assign look_in_range = ({1'b0, look_data} < NC_L);
    assign look_idx      = look_data[NIW-1:0];
    assign look_held     = look_in_range && seen_reg[look_idx];
    assign look_full     = look_held ? (n_two_reg >= RM_L) : (n_one_reg >= RM_L);

    assign len_a     = mix_reg ? n_one_reg : len1_reg;
    assign len_b     = mix_reg ? n_two_reg : len2_reg;
    assign sel_len   = side_reg ? len_b : len_a;
    assign sel_ok    = (idx_reg < sel_len);
    assign idx_inc   = idx_reg + 1'b1;
    assign slot_free = !out_valid_reg || m_ready;
    assign wr_data   = mix_reg ? (side_reg ? c2_rdata : c1_rdata)
                               : (side_reg ? p2_rdata : p1_rdata);
    assign wr_last   = side_reg ? (idx_inc == len_b)
                                : ((idx_inc == len_a) && (len_b == '0));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (q_cmd.op == OP_RUN))
                begin
                    state_next = q_cmd.mix ? ST_PICK : ST_SEL;
                end
            end
            ST_PICK: state_next = pick_any ? ST_LOOK : ST_SEL;
            ST_LOOK:
            begin
                if (!look_cust)
                begin
                    state_next = ST_PICK;
                end
                else if (look_full)
                begin
                    state_next = ST_SEL;
                end
                else
                begin
                    state_next = ST_PICK;
                end
            end
            ST_SEL:
            begin
                if (sel_ok)
                begin
                    state_next = ST_RD;
                end
                else if (side_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:   state_next = ST_WR;
            ST_WR:   state_next = slot_free ? ST_SEL : ST_WR;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        len1_next  = len1_reg;
        len2_next  = len2_reg;
        ptr1_next  = ptr1_reg;
        ptr2_next  = ptr2_reg;
        got1_next  = got1_reg;
        got2_next  = got2_reg;
        n_one_next = n_one_reg;
        n_two_next = n_two_reg;
        turn_next  = turn_reg;
        cur_next   = cur_reg;
        mix_next   = mix_reg;
        side_next  = side_reg;
        idx_next   = idx_reg;
        seen_next  = seen_reg;
        p1_we      = 1'b0;
        p2_we      = 1'b0;
        c1_we      = 1'b0;
        c2_we      = 1'b0;
        p1_re      = 1'b0;
        p2_re      = 1'b0;
        c1_re      = 1'b0;
        c2_re      = 1'b0;
        p1_raddr   = ptr1_reg[AW-1:0];
        p2_raddr   = ptr2_reg[AW-1:0];
        out_load   = 1'b0;
        q_pop      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_LOAD_ONE:
                        begin
                            if (len1_reg < RM_L)
                            begin
                                p1_we     = 1'b1;
                                len1_next = len1_reg + 1'b1;
                            end
                        end
                        OP_LOAD_TWO:
                        begin
                            if (len2_reg < RM_L)
                            begin
                                p2_we     = 1'b1;
                                len2_next = len2_reg + 1'b1;
                            end
                        end
                        OP_RUN:
                        begin
                            seen_next  = '0;
                            ptr1_next  = '0;
                            ptr2_next  = '0;
                            got1_next  = '0;
                            got2_next  = '0;
                            n_one_next = '0;
                            n_two_next = '0;
                            turn_next  = 1'b0;
                            mix_next   = q_cmd.mix;
                            side_next  = 1'b0;
                            idx_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PICK:
            begin
                p1_re    = 1'b1;
                p2_re    = 1'b1;
                cur_next = pick_side;
            end
            ST_LOOK:
            begin
                if (cur_reg)
                begin
                    ptr2_next = ptr2_reg + 1'b1;
                end
                else
                begin
                    ptr1_next = ptr1_reg + 1'b1;
                end
                // depots are skipped; a full target child ends the interleave
                if (look_cust && !look_full)
                begin
                    turn_next = !cur_reg;
                    if (cur_reg)
                    begin
                        got2_next = got2_reg + 1'b1;
                    end
                    else
                    begin
                        got1_next = got1_reg + 1'b1;
                    end
                    if (look_held)
                    begin
                        c2_we      = 1'b1;
                        n_two_next = n_two_reg + 1'b1;
                    end
                    else
                    begin
                        c1_we      = 1'b1;
                        n_one_next = n_one_reg + 1'b1;
                        if (look_in_range)
                        begin
                            seen_next[look_idx] = 1'b1;
                        end
                    end
                end
            end
            ST_SEL:
            begin
                if (!sel_ok && !side_reg)
                begin
                    side_next = 1'b1;
                    idx_next  = '0;
                end
            end
            ST_RD:
            begin
                if (mix_reg)
                begin
                    c1_re = !side_reg;
                    c2_re = side_reg;
                end
                else
                begin
                    p1_re    = !side_reg;
                    p2_re    = side_reg;
                    p1_raddr = idx_reg[AW-1:0];
                    p2_raddr = idx_reg[AW-1:0];
                end
            end
            ST_WR:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    idx_next = idx_inc;
                end
            end
            default: ;
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len1_reg      <= '0;
            len2_reg      <= '0;
            ptr1_reg      <= '0;
            ptr2_reg      <= '0;
            got1_reg      <= '0;
            got2_reg      <= '0;
            n_one_reg     <= '0;
            n_two_reg     <= '0;
            turn_reg      <= 1'b0;
            cur_reg       <= 1'b0;
            mix_reg       <= 1'b0;
            side_reg      <= 1'b0;
            idx_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len1_reg      <= len1_next;
            len2_reg      <= len2_next;
            ptr1_reg      <= ptr1_next;
            ptr2_reg      <= ptr2_next;
            got1_reg      <= got1_next;
            got2_reg      <= got2_next;
            n_one_reg     <= n_one_next;
            n_two_reg     <= n_two_next;
            turn_reg      <= turn_next;
            cur_reg       <= cur_next;
            mix_reg       <= mix_next;
            side_reg      <= side_next;
            idx_reg       <= idx_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_child_reg <= side_reg;
            out_node_reg  <= wr_data;
            out_last_reg  <= wr_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_child = out_child_reg;
    assign m_node  = out_node_reg;
    assign m_last  = out_last_reg;

    `RIC_ASSERT_ALWAYS(a_len_bound, (len1_reg <= RM_L) && (len2_reg <= RM_L), "parent length past capacity")
    `RIC_ASSERT_ALWAYS(a_ptr_bound, (ptr1_reg <= len1_reg) && (ptr2_reg <= len2_reg), "scan pointer past parent length")
    `RIC_ASSERT_NEXT(a_seen_clear, (state_reg == ST_IDLE) && q_valid && (q_cmd.op == OP_RUN), seen_reg == '0, "visited map not cleared at run start")
    `RIC_ASSERT_IMPLIES(a_rd_range, state_reg == ST_RD, idx_reg < sel_len, "emit read beyond list length")

endmodule

>>> rtl/route_interleave_crossover_core.sv
// Route crossover core: two parent routes in, interleaved or copied children out.
// Usage:
//   s_axis carries one item per transfer: tuser is the kind (load parent one,
//   load parent two, run), tdata the node and the two random draws. Loads
//   append to a parent route, dropped once it holds ROUTE_MAX nodes.
//   A run sends every result on m_axis: tuser is the child, tdata the node,
//   tlast marks the final result of the run. Child one comes first, then
//   child two.
//   cfg_we writes customer_count (index 0) or cross_threshold (index 1);
//   write only while no run is in flight.
// Sequencing:
//   A load is handled in the sequencer's idle state. A mixing run scans
//   parent nodes through the pick and look states (both parent stores read
//   per step); every run then emits results through the select, read and
//   write states (store read, output register handoff).
//   A four-entry command queue lets input transfers continue while a run
//   is being worked.
// Reset clears lengths, visited map, queue and output valid; parent stores
// need no clearing. A stalled receiver holds the output register and the
// sequencer waits; input is taken until the queue fills.
module route_interleave_crossover_core
    import ric_pkg::*;
#(
    parameter int ROUTE_MAX   = ROUTE_MAX_DEF,
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // node, cross_draw, mix_draw, zero pad
    input  logic [KIND_W-1:0]      s_axis_tuser,  // kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // node_out, zero pad
    output logic [0:0]             m_axis_tuser,  // child
    output logic                   m_axis_tlast
);

    logic              push, q_full, q_pop, q_valid;
    cmd_t              push_cmd, q_cmd;
    logic [CC_W-1:0]   customer_count;
    logic              m_child;
    logic [NODE_W-1:0] m_node;

    ric_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_kind        (s_axis_tuser),
        .in_node        (s_axis_tdata[NODE_W-1:0]),
        .in_cross       (s_axis_tdata[NODE_W +: DRAW_W]),
        .in_mix         (s_axis_tdata[NODE_W + DRAW_W +: DRAW_W]),
        .q_full         (q_full),
        .push           (push),
        .push_cmd       (push_cmd),
        .customer_count (customer_count)
    );

    ric_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    ric_back #(.ROUTE_MAX(ROUTE_MAX), .NODE_COUNT(NODE_COUNT)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .customer_count (customer_count),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .m_child        (m_child),
        .m_node         (m_node),
        .m_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - NODE_W){1'b0}}, m_node};
    assign m_axis_tuser = m_child;

endmodule
